### design/mp2a_pkg.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax: shared package
// Types, register indexes and fixed field widths used by the core, controller and datapath files.
// ----------------------------------------------------------------------------
package mp2a_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_SIDE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_HEIGHT = 2'd3;

    // Register widths.
    localparam int KSZ_BITS    = 3;
    localparam int STRIDE_BITS = 4;
    localparam int DIM_BITS    = 11;

    // Width of a kernel count (the kernel never exceeds eight).
    localparam int KCNT_W = 4;

    // Result field widths.
    localparam int POS_BITS = 20;
    localparam int IDX_BITS = 10;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MULT,
        ST_EMIT
    } mp2a_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the offered sample and write it to the line store
        logic rd;       // read the next window column from all row banks
        logic mul;      // form row times plane width for the winning sample
        logic load;     // load the result into the output register
    } mp2a_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;      // the offered sample closes a window
        logic last_rd;  // the current column read is the last of the window
        logic out_free; // the output register can take a new result
    } mp2a_stat_t;

endpackage

### design/max_pool_2d_argmax_core.sv
// ----------------------------------------------------------------------------
// Max pooling 2-D with argmax: top level
// Pools one channel plane in raster order and reports each window maximum
// together with its position in the plane.
// ----------------------------------------------------------------------------
// Samples enter one per transfer in raster order. A sample that closes no
// window leaves the input open; one that closes a window holds it off
// until its result is loaded: the window is read back one column per cycle
// from the row banks of the line store (all banks in parallel, one read
// port each), the last column is compared, the row of the winner is
// multiplied by the plane width, and the result is loaded into the output
// register; the load waits while that register still holds an untaken
// result. Ties go to the first sample in raster order. The line store needs
// no clearing after reset, since a window only reads rows of the current
// plane. A write to any configuration register restarts the plane.
module max_pool_2d_argmax_core
    import mp2a_pkg::*;
#(
    parameter int MAX_KERNEL  = 4,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    // Sample input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_value,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_peak_value,
    output logic [POS_BITS-1:0]           m_max_position,
    output logic [IDX_BITS-1:0]           m_out_row,
    output logic [IDX_BITS-1:0]           m_out_col,
    output logic                          m_plane_done
);

    mp2a_cmd_t  cmd;
    mp2a_stat_t stat;

    // Controller.
    mp2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath.
    mp2a_datapath #(
        .MAX_KERNEL  (MAX_KERNEL),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_sample_value (s_sample_value),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_value   (m_peak_value),
        .m_max_position (m_max_position),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_plane_done   (m_plane_done)
    );

    // At most one controller command is active in any cycle.
    a_one_cmd : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.rd, cmd.mul, cmd.load}))
        else $error("more than one datapath command in a cycle");

    // A sample that closes a window stops further input for the scan.
    a_hit_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && stat.hit) |=> !s_ready)
        else $error("input taken during a window scan");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    // The multiply for the position always follows a completed scan.
    a_mul_after_scan : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> ($past(!cmd.rd) && $past(cmd.rd, 2)))
        else $error("position multiply out of sequence");

endmodule

### design/mp2a_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module mp2a_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/mp2a_ctrl.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax: controller
// Sequences sample acceptance, the column scan of a window, the position
// multiply and the load of the output register.
// ----------------------------------------------------------------------------
module mp2a_ctrl
    import mp2a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  mp2a_stat_t stat,
    output mp2a_cmd_t  cmd
);

    mp2a_state_t state_reg;
    mp2a_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && stat.hit) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd = 1'b1;
                if (stat.last_rd) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last column is compared in this cycle.
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/mp2a_datapath.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax: datapath
// Configuration registers, raster counters, row-bank line store, window
// compare, position arithmetic and the output register.
// ----------------------------------------------------------------------------
module mp2a_datapath
    import mp2a_pkg::*;
#(
    parameter int MAX_KERNEL  = 4,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_value,
    input  mp2a_cmd_t                     cmd,
    output mp2a_stat_t                    stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_peak_value,
    output logic [POS_BITS-1:0]           m_max_position,
    output logic [IDX_BITS-1:0]           m_out_row,
    output logic [IDX_BITS-1:0]           m_out_col,
    output logic                          m_plane_done
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int BKW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int NCW    = CW + 5;
    localparam int NRW    = RW + 5;
    localparam int WSW    = WW + 4;
    localparam int HSW    = HW + 4;
    localparam int PROD_W = RW + WW;
    localparam int PSW    = PROD_W + POS_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KSZ_BITS-1:0]    kernel_reg,  kernel_next;
    logic [STRIDE_BITS-1:0] stride_reg,  stride_next;
    logic [DIM_BITS-1:0]    width_reg,   width_next;
    logic [DIM_BITS-1:0]    height_reg,  height_next;

    always_comb begin
        kernel_next = kernel_reg;
        stride_next = stride_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_WIN_SIDE:     kernel_next = cfg_wdata[KSZ_BITS-1:0];
                REG_STRIDE:       stride_next = cfg_wdata[STRIDE_BITS-1:0];
                REG_PLANE_WIDTH:  width_next  = cfg_wdata[DIM_BITS-1:0];
                REG_PLANE_HEIGHT: height_next = cfg_wdata[DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg <= KSZ_BITS'(2);
            stride_reg <= STRIDE_BITS'(2);
            width_reg  <= DIM_BITS'(32);
            height_reg <= DIM_BITS'(32);
        end else begin
            kernel_reg <= kernel_next;
            stride_reg <= stride_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Register values clamped to their legal ranges.
    logic [KCNT_W-1:0]      k_eff;
    logic [STRIDE_BITS-1:0] s_eff;
    logic [WW-1:0]          w_eff;
    logic [HW-1:0]          h_eff;

    always_comb begin
        if (kernel_reg == '0) begin
            k_eff = KCNT_W'(1);
        end else if (32'(kernel_reg) > MAX_KERNEL) begin
            k_eff = KCNT_W'(MAX_KERNEL);
        end else begin
            k_eff = KCNT_W'(kernel_reg);
        end
        s_eff = (stride_reg == '0) ? STRIDE_BITS'(1) : stride_reg;
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Raster position and window tracking
    // ------------------------------------------------------------------
    // The next window end column and row are tracked incrementally; a
    // fresh flag means the tracker sits at the first window (kernel - 1).
    logic [CW-1:0]       col_reg,     col_next;
    logic [RW-1:0]       row_reg,     row_next;
    logic [BKW-1:0]      bank_reg,    bank_next;
    logic [NCW-1:0]      nxt_c_reg,   nxt_c_next;
    logic [NRW-1:0]      nxt_r_reg,   nxt_r_next;
    logic                c_fresh_reg, c_fresh_next;
    logic                r_fresh_reg, r_fresh_next;
    logic [IDX_BITS-1:0] ocol_reg,    ocol_next;
    logic [IDX_BITS-1:0] orow_reg,    orow_next;

    logic [NCW-1:0] nxt_c_eff;
    logic [NRW-1:0] nxt_r_eff;
    logic           col_hit;
    logic           row_hit;
    logic           row_end;
    logic           plane_end;
    logic           last_col;
    logic           last_row;

    always_comb begin
        nxt_c_eff = c_fresh_reg ? NCW'(k_eff - KCNT_W'(1)) : nxt_c_reg;
        nxt_r_eff = r_fresh_reg ? NRW'(k_eff - KCNT_W'(1)) : nxt_r_reg;
        col_hit   = (NCW'(col_reg) == nxt_c_eff);
        row_hit   = (NRW'(row_reg) == nxt_r_eff);
        row_end   = ((WW'(col_reg) + WW'(1)) >= w_eff);
        plane_end = ((HW'(row_reg) + HW'(1)) >= h_eff);
        // No further window fits to the right of or below this one.
        last_col  = ((WSW'(col_reg) + WSW'(s_eff)) >= WSW'(w_eff));
        last_row  = ((HSW'(row_reg) + HSW'(s_eff)) >= HSW'(h_eff));
    end

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        bank_next    = bank_reg;
        nxt_c_next   = nxt_c_reg;
        nxt_r_next   = nxt_r_reg;
        c_fresh_next = c_fresh_reg;
        r_fresh_next = r_fresh_reg;
        ocol_next    = ocol_reg;
        orow_next    = orow_reg;
        if (cfg_we) begin
            // Any register write restarts the plane.
            col_next     = '0;
            row_next     = '0;
            bank_next    = '0;
            c_fresh_next = 1'b1;
            r_fresh_next = 1'b1;
            ocol_next    = '0;
            orow_next    = '0;
        end else if (cmd.accept) begin
            if (row_end) begin
                col_next     = '0;
                c_fresh_next = 1'b1;
                ocol_next    = '0;
                if (plane_end) begin
                    row_next     = '0;
                    bank_next    = '0;
                    r_fresh_next = 1'b1;
                    orow_next    = '0;
                end else begin
                    row_next  = row_reg + RW'(1);
                    bank_next = (32'(bank_reg) == MAX_KERNEL - 1) ? '0
                                                                   : bank_reg + BKW'(1);
                    if (row_hit) begin
                        nxt_r_next   = nxt_r_eff + NRW'(s_eff);
                        r_fresh_next = 1'b0;
                        orow_next    = orow_reg + IDX_BITS'(1);
                    end
                end
            end else begin
                col_next = col_reg + CW'(1);
                if (col_hit) begin
                    nxt_c_next   = nxt_c_eff + NCW'(s_eff);
                    c_fresh_next = 1'b0;
                    ocol_next    = ocol_reg + IDX_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            bank_reg    <= '0;
            c_fresh_reg <= 1'b1;
            r_fresh_reg <= 1'b1;
            ocol_reg    <= '0;
            orow_reg    <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            bank_reg    <= bank_next;
            c_fresh_reg <= c_fresh_next;
            r_fresh_reg <= r_fresh_next;
            ocol_reg    <= ocol_next;
            orow_reg    <= orow_next;
        end
    end

    // The trackers are only read once their fresh flag has been cleared.
    always_ff @(posedge aclk) begin
        nxt_c_reg <= nxt_c_next;
        nxt_r_reg <= nxt_r_next;
    end

    // ------------------------------------------------------------------
    // Window context captured when a window closes
    // ------------------------------------------------------------------
    logic [CW-1:0]       c0_reg,    c0_next;
    logic [RW-1:0]       r0_reg,    r0_next;
    logic [BKW-1:0]      bank0_reg, bank0_next;
    logic [KCNT_W-1:0]   k_lat_reg, k_lat_next;
    logic [IDX_BITS-1:0] wcol_reg,  wcol_next;
    logic [IDX_BITS-1:0] wrow_reg,  wrow_next;
    logic                done_reg,  done_next;
    logic [BKW:0]        bank0_sum;

    always_comb begin
        // Bank of the window's top row, modulo the number of banks.
        bank0_sum = (BKW+1)'(bank_reg) + (BKW+1)'(MAX_KERNEL) + (BKW+1)'(1)
                    - (BKW+1)'(k_eff);
        if (32'(bank0_sum) >= MAX_KERNEL) begin
            bank0_sum = bank0_sum - (BKW+1)'(MAX_KERNEL);
        end
        c0_next    = c0_reg;
        r0_next    = r0_reg;
        bank0_next = bank0_reg;
        k_lat_next = k_lat_reg;
        wcol_next  = wcol_reg;
        wrow_next  = wrow_reg;
        done_next  = done_reg;
        if (cmd.accept && col_hit && row_hit) begin
            c0_next    = CW'(NCW'(col_reg) + NCW'(1) - NCW'(k_eff));
            r0_next    = RW'(NRW'(row_reg) + NRW'(1) - NRW'(k_eff));
            bank0_next = BKW'(bank0_sum);
            k_lat_next = k_eff;
            wcol_next  = ocol_reg;
            wrow_next  = orow_reg;
            done_next  = last_col && last_row;
        end
    end

    always_ff @(posedge aclk) begin
        c0_reg    <= c0_next;
        r0_reg    <= r0_next;
        bank0_reg <= bank0_next;
        k_lat_reg <= k_lat_next;
        wcol_reg  <= wcol_next;
        wrow_reg  <= wrow_next;
        done_reg  <= done_next;
    end

    // ------------------------------------------------------------------
    // Column scan counter
    // ------------------------------------------------------------------
    logic [KCNT_W-1:0] idx_reg,      idx_next;
    logic [KCNT_W-1:0] cmp_idx_reg,  cmp_idx_next;
    logic              rd_pend_reg,  rd_pend_next;
    logic [CW-1:0]     rd_addr;

    always_comb begin
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        rd_pend_next = cmd.rd;
        if (cmd.accept) begin
            idx_next = '0;
        end else if (cmd.rd) begin
            idx_next     = idx_reg + KCNT_W'(1);
            cmp_idx_next = idx_reg;
        end
        rd_addr = c0_reg + CW'(idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    // ------------------------------------------------------------------
    // Line store: one bank per kernel row, indexed by column
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] bank_q [MAX_KERNEL];

    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        mp2a_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (cmd.accept && (bank_reg == BKW'(b))),
            .waddr (col_reg),
            .wdata (s_sample_value),
            .re    (cmd.rd),
            .raddr (rd_addr),
            .rdata (bank_q[b])
        );
    end

    // ------------------------------------------------------------------
    // Column maximum: rows top to bottom, strict compare keeps the first
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] cand_val;
    logic [BKW-1:0]         cand_lane;
    logic                   cand_have;
    logic [BKW:0]           lane_sum;
    logic [BKW-1:0]         lane_bank;

    always_comb begin
        cand_val  = '0;
        cand_lane = '0;
        cand_have = 1'b0;
        lane_sum  = '0;
        lane_bank = '0;
        for (int l = 0; l < MAX_KERNEL; l++) begin
            lane_sum = (BKW+1)'(bank0_reg) + (BKW+1)'(l);
            if (32'(lane_sum) >= MAX_KERNEL) begin
                lane_sum = lane_sum - (BKW+1)'(MAX_KERNEL);
            end
            lane_bank = BKW'(lane_sum);
            if ((KCNT_W'(l) < k_lat_reg) &&
                (!cand_have || ($signed(bank_q[lane_bank]) > $signed(cand_val)))) begin
                cand_val  = bank_q[lane_bank];
                cand_lane = BKW'(l);
                cand_have = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Running window maximum across columns
    // ------------------------------------------------------------------
    // A later column wins on a strictly larger value, or on an equal value
    // from an earlier row, which keeps the first sample in raster order.
    logic [SAMPLE_BITS-1:0] best_val_reg,  best_val_next;
    logic [BKW-1:0]         best_lane_reg, best_lane_next;
    logic [KCNT_W-1:0]      best_col_reg,  best_col_next;
    logic                   have_reg,      have_next;
    logic                   take;

    always_comb begin
        take = !have_reg ||
               ($signed(cand_val) > $signed(best_val_reg)) ||
               ((cand_val == best_val_reg) && (cand_lane < best_lane_reg));
        best_val_next  = best_val_reg;
        best_lane_next = best_lane_reg;
        best_col_next  = best_col_reg;
        have_next      = have_reg;
        if (cmd.accept) begin
            have_next = 1'b0;
        end else if (rd_pend_reg && take) begin
            best_val_next  = cand_val;
            best_lane_next = cand_lane;
            best_col_next  = cmp_idx_reg;
            have_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_val_reg  <= best_val_next;
        best_lane_reg <= best_lane_next;
        best_col_reg  <= best_col_next;
    end

    // ------------------------------------------------------------------
    // Position of the maximum: row times plane width, then add the column
    // ------------------------------------------------------------------
    logic [RW-1:0]     best_row;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PSW-1:0]    pos_sum;

    always_comb begin
        best_row  = r0_reg + RW'(best_lane_reg);
        prod_next = cmd.mul ? PROD_W'(best_row) * PROD_W'(w_eff) : prod_reg;
        pos_sum   = PSW'(prod_reg) + PSW'(c0_reg + CW'(best_col_reg));
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_val_reg,   m_val_next;
    logic [POS_BITS-1:0]    m_pos_reg,   m_pos_next;
    logic [IDX_BITS-1:0]    m_row_reg,   m_row_next;
    logic [IDX_BITS-1:0]    m_col_reg,   m_col_next;
    logic                   m_done_reg,  m_done_next;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_val_next   = m_val_reg;
        m_pos_next   = m_pos_reg;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_done_next  = m_done_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
            m_val_next   = best_val_reg;
            m_pos_next   = pos_sum[POS_BITS-1:0];
            m_row_next   = wrow_reg;
            m_col_next   = wcol_reg;
            m_done_next  = done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_val_reg  <= m_val_next;
        m_pos_reg  <= m_pos_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_done_reg <= m_done_next;
    end

    // Status to the controller.
    always_comb begin
        stat.hit      = col_hit && row_hit;
        stat.last_rd  = ((idx_reg + KCNT_W'(1)) == k_lat_reg);
        stat.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_peak_value   = $signed(m_val_reg);
    assign m_max_position = m_pos_reg;
    assign m_out_row      = m_row_reg;
    assign m_out_col      = m_col_reg;
    assign m_plane_done   = m_done_reg;

endmodule
